// ----- rtl/core/contact_impulse_resolver_defines.svh -----
// Assertion macros for the contact impulse resolver.
// Used by the top level; expects signals clk and rst in scope.
`ifndef CONTACT_IMPULSE_RESOLVER_DEFINES_SVH
`define CONTACT_IMPULSE_RESOLVER_DEFINES_SVH

// Same-cycle implication
`define CIR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CIR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cir_pkg.sv -----
// Shared types, constants and saturation helpers for the contact impulse resolver.
// No dependencies.
package cir_pkg;

  localparam int NUM_BODIES_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IDX_W          = 6;
  localparam int CFG_W          = 17;
  localparam int IN_DATA_W      = 144;
  localparam int IN_USER_W      = 4;
  localparam int OUT_DATA_W     = 96;
  localparam int OUT_USER_W     = 2;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_CONTACT = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] KIND_VEL  = 2'd0;
  localparam logic [1:0] KIND_ACC  = 2'd1;
  localparam logic [1:0] KIND_POS  = 2'd2;
  localparam logic [1:0] KIND_MASS = 2'd3;

  localparam logic [1:0] REG_RESTITUTION = 2'd0;
  localparam logic [1:0] REG_FRICTION    = 2'd1;
  localparam logic [1:0] REG_STEP        = 2'd2;

  localparam logic [CFG_W-1:0] RESTITUTION_RST = 17'd32768;
  localparam logic [CFG_W-1:0] FRICTION_RST    = 17'd13107;
  localparam logic [CFG_W-1:0] STEP_RST        = 17'd0;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef enum logic [2:0] {MA_W, MA_T, MA_IMP, MA_N, MA_G} mul_a_t;
  typedef enum logic [1:0] {MB_N, MB_G, MB_G2} mul_b_t;
  typedef enum logic [1:0] {T_HOLD, T_RDAT, T_Q} t_sel_t;
  typedef enum logic [1:0] {W_HOLD, W_SUB, W_ADD, W_DAMP} w_sel_t;
  typedef enum logic [1:0] {WD_W, WD_IN, WD_ZERO} wd_sel_t;

  typedef struct packed {
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    t_sel_t  t_sel;
    w_sel_t  w_sel;
    logic    imp_ld;
    logic    we;
    wd_sel_t wd_sel;
  } lane_ctl_t;

  function automatic logic signed [65:0] sx32(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [65:0] sx64(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fff_ffff;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/cir_lane.sv -----
// One vector-component lane: body store for that component, a multiplier and
// saturating add/subtract. Depends on cir_pkg.
module cir_lane #(
  parameter int NUM_BODIES = cir_pkg::NUM_BODIES_DEF,
  parameter int FRAC_BITS  = cir_pkg::FRAC_BITS_DEF,
  localparam int AW        = $clog2(NUM_BODIES) + 2
) (
  input  logic                clk,
  input  cir_pkg::lane_ctl_t  ctl,
  input  logic [AW-1:0]       addr,
  input  logic signed [31:0]  n_in,
  input  logic signed [31:0]  g,
  input  logic signed [31:0]  g2,
  input  logic                hb,
  output logic signed [31:0]  rdat,
  output logic signed [63:0]  q
);

  logic signed [31:0] mem [NUM_BODIES*4];
  logic signed [31:0] t;
  logic signed [31:0] w;
  logic signed [31:0] imp;
  logic signed [31:0] wdata;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] prod;

  // Select memory write data
  always_comb begin
    case (ctl.wd_sel)
      cir_pkg::WD_W:  wdata = w;
      cir_pkg::WD_IN: wdata = n_in;
      default:        wdata = '0;
    endcase
  end

  // Select multiplier operands
  always_comb begin
    case (ctl.mul_a)
      cir_pkg::MA_W:   opa = w;
      cir_pkg::MA_T:   opa = t;
      cir_pkg::MA_IMP: opa = imp;
      cir_pkg::MA_N:   opa = n_in;
      default:         opa = g;
    endcase
    case (ctl.mul_b)
      cir_pkg::MB_N: opb = n_in;
      cir_pkg::MB_G: opb = g;
      default:       opb = g2;
    endcase
    prod = opa * opb;
  end

  // Store access, read data registered
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    rdat <= mem[addr];
  end

  // Product register, floor shift by the fraction width
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      q <= prod >>> FRAC_BITS;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (ctl.t_sel)
      cir_pkg::T_RDAT: t <= rdat;
      cir_pkg::T_Q:    t <= cir_pkg::sat32(cir_pkg::sx64(q));
      default:         t <= t;
    endcase
    case (ctl.w_sel)
      cir_pkg::W_SUB:  w <= cir_pkg::sat32(cir_pkg::sx32(t) -
                                           (hb ? cir_pkg::sx32(rdat) : 66'sd0));
      cir_pkg::W_ADD:  w <= cir_pkg::sat32(cir_pkg::sx32(rdat) + cir_pkg::sx64(q));
      cir_pkg::W_DAMP: w <= cir_pkg::sat32(cir_pkg::sx32(w) - cir_pkg::sx32(t));
      default:         w <= w;
    endcase
    if (ctl.imp_ld) begin
      imp <= cir_pkg::sat32(cir_pkg::sx64(q));
    end
  end

endmodule

// ----- rtl/core/cir_merge.sv -----
// Merge stage: adds the three lane products into one saturated dot product.
// Depends on cir_pkg.
module cir_merge (
  input  logic               clk,
  input  logic signed [63:0] q0,
  input  logic signed [63:0] q1,
  input  logic signed [63:0] q2,
  output logic signed [31:0] dot
);

  // Register the saturated sum
  always_ff @(posedge clk) begin
    dot <= cir_pkg::sat32(cir_pkg::sx64(q0) + cir_pkg::sx64(q1) + cir_pkg::sx64(q2));
  end

endmodule

// ----- rtl/core/cir_div.sv -----
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// both positive, quotient saturated to 32 bits. Depends on nothing.
module cir_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [32:0]        num,
  input  logic [32:0]        den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int DVW = 33 + FRAC_BITS;
  localparam int CW  = $clog2(DVW + 1);

  logic [32:0]     rem;
  logic [DVW-1:0]  quo_r;
  logic [32:0]     den_r;
  logic [CW-1:0]   cnt;
  logic [33:0]     trial;
  logic [33:0]     diff;

  assign trial = {rem, quo_r[DVW-1]};
  assign diff  = trial - {1'b0, den_r};

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo_r <= {num, {FRAC_BITS{1'b0}}};
        den_r <= den;
        rem   <= '0;
        cnt   <= CW'(DVW);
        busy  <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, den_r}) begin
          rem   <= diff[32:0];
          quo_r <= {quo_r[DVW-2:0], 1'b1};
        end else begin
          rem   <= trial[32:0];
          quo_r <= {quo_r[DVW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate to the signed 32-bit range
  assign quo = (|quo_r[DVW-1:31]) ? 32'sh7fff_ffff : $signed(quo_r[31:0]);

endmodule

// ----- rtl/core/contact_impulse_resolver.sv -----
// Contact impulse resolver top level: sequencer, configuration registers,
// three component lanes, merge stage and divider. Depends on cir_pkg,
// cir_lane, cir_merge, cir_div and contact_impulse_resolver_defines.svh.
//
// Usage:
//   Items arrive on the s_* stream (one transaction per item) and each gives
//   exactly one result on the m_* stream. Register writes use cfg_* and are
//   always ready; write them only while the block is idle.
//   A contact finds the separating velocity; if the bodies approach, it
//   computes the impulse with a divide and updates each body's velocity;
//   then, for a positive penetration, it divides again and moves each
//   body's position. Values are Q16.16 with the default FRAC_BITS. The
//   bit-serial divider (33 + FRAC_BITS iterations) and the single store
//   port per lane set the contact time.
//   One item is worked at a time; s_tready is high only when the sequencer
//   is idle. The result sits in an output register, so a new item is taken
//   while it waits; a finished item holds in the final step until the
//   waiting result is taken. Reset: a clearing pass zeroes all 4 * NUM_BODIES
//   store words, with s_tready low; registers take their defaults at once.
`include "contact_impulse_resolver_defines.svh"

module contact_impulse_resolver #(
  parameter int NUM_BODIES = cir_pkg::NUM_BODIES_DEF,
  parameter int FRAC_BITS  = cir_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // body_a[5:0], body_b[11:6], has_b[12], vec_x[44:13], vec_y[76:45],
  // vec_z[108:77], penetration[140:109], zero fill
  input  logic [cir_pkg::IN_DATA_W-1:0]     s_tdata,
  // op[1:0], field_kind[3:2]
  input  logic [cir_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [cir_pkg::OUT_DATA_W-1:0]    m_tdata,
  // velocity_changed[0], position_changed[1]
  output logic [cir_pkg::OUT_USER_W-1:0]    m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [cir_pkg::CFG_W-1:0]         cfg_data
);

  localparam int IW = $clog2(NUM_BODIES);
  localparam int AW = IW + 2;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BODIES * 4 - 1);

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_READ, S_READ2,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7,
    S_V1, S_V2, S_V3, S_V4, S_V5, S_V6, S_V7, S_V8, S_V9, S_V10, S_V11,
    S_VDIV, S_VDW, S_V12, S_V13,
    S_VUR, S_VU1, S_VU2, S_VU3, S_VU4, S_VU5, S_VU6, S_VU7, S_VU8, S_VU9, S_VU10,
    S_P0, S_PDW, S_P1, S_P2, S_PR, S_PU1, S_PU2, S_PU3, S_FIN
  } state_t;

  state_t state;

  // Configuration
  logic [cir_pkg::CFG_W-1:0] restitution;
  logic [cir_pkg::CFG_W-1:0] friction_coef;
  logic [cir_pkg::CFG_W-1:0] step_time;

  // Latched item
  logic [1:0]                op_r;
  logic [cir_pkg::IDX_W-1:0] a_r;
  logic [cir_pkg::IDX_W-1:0] b_r;
  logic                      hb_r;
  logic [1:0]                kind_r;
  logic signed [31:0]        n_r [3];
  logic signed [31:0]        pen_r;

  // Contact scalars
  logic signed [31:0] im_a;
  logic signed [31:0] im_b;
  logic signed [31:0] neg_b;
  logic signed [31:0] mass_a;
  logic signed [31:0] mass_b;
  logic signed [32:0] tim;
  logic signed [31:0] sv;
  logic signed [31:0] nsv;
  logic signed [31:0] g;
  logic signed [31:0] g2;
  logic               side;
  logic               vflag;
  logic               pflag;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic [AW-1:0]      clr_addr;

  // Lane and unit wires
  cir_pkg::lane_ctl_t ctl;
  logic [AW-1:0]      addr;
  logic [cir_pkg::IDX_W-1:0] body_sel;
  logic [1:0]         kind_sel;
  logic signed [31:0] rdat [3];
  logic signed [63:0] q [3];
  logic signed [31:0] dot;
  logic               div_start;
  logic [32:0]        div_num;
  logic               div_busy;
  logic               div_done;
  logic signed [31:0] div_quo;
  logic signed [31:0] q0_sat;
  logic signed [31:0] nsv_sum;
  logic signed [32:0] nsv_diff;
  logic               tim_pos;
  logic               in_acc;
  logic               a_ok;
  logic               b_ok;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign a_ok      = int'(s_tdata[5:0]) < NUM_BODIES;
  assign b_ok      = int'(s_tdata[11:6]) < NUM_BODIES;
  assign tim_pos   = !tim[32] && (tim != '0);
  assign q0_sat    = cir_pkg::sat32(cir_pkg::sx64(q[0]));
  assign nsv_sum   = cir_pkg::sat32(cir_pkg::sx32(nsv) + cir_pkg::sx64(q[0]));
  assign nsv_diff  = {nsv[31], nsv} - {sv[31], sv};
  assign div_start = (state == S_VDIV) || (state == S_P0 && !pen_r[31] &&
                     (pen_r != '0) && tim_pos);
  assign div_num   = (state == S_VDIV) ? nsv_diff : {1'b0, pen_r};

  // Store address and lane commands per step
  always_comb begin
    ctl      = '{mul_en: 1'b0, mul_a: cir_pkg::MA_W, mul_b: cir_pkg::MB_N,
                 t_sel: cir_pkg::T_HOLD, w_sel: cir_pkg::W_HOLD, imp_ld: 1'b0,
                 we: 1'b0, wd_sel: cir_pkg::WD_W};
    body_sel = side ? b_r : a_r;
    kind_sel = cir_pkg::KIND_VEL;
    case (state)
      S_WRITE: begin
        body_sel   = a_r;
        kind_sel   = kind_r;
        ctl.we     = 1'b1;
        ctl.wd_sel = cir_pkg::WD_IN;
      end
      S_READ: begin
        body_sel = a_r;
        kind_sel = kind_r;
      end
      S_C0: begin
        body_sel = a_r;
        kind_sel = cir_pkg::KIND_MASS;
      end
      S_C1: begin
        body_sel = b_r;
        kind_sel = cir_pkg::KIND_MASS;
      end
      S_C2: body_sel = a_r;
      S_C3: begin
        body_sel  = b_r;
        ctl.t_sel = cir_pkg::T_RDAT;
      end
      S_C4, S_V4: ctl.w_sel = cir_pkg::W_SUB;
      S_C5, S_V5: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = cir_pkg::MA_W;
        ctl.mul_b  = cir_pkg::MB_N;
      end
      S_V1, S_V8, S_V10: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = cir_pkg::MA_G;
        ctl.mul_b  = cir_pkg::MB_G2;
      end
      S_V2: begin
        body_sel = a_r;
        kind_sel = cir_pkg::KIND_ACC;
      end
      S_V3: begin
        body_sel  = b_r;
        kind_sel  = cir_pkg::KIND_ACC;
        ctl.t_sel = cir_pkg::T_RDAT;
      end
      S_V12, S_P1: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = cir_pkg::MA_N;
        ctl.mul_b  = cir_pkg::MB_G;
      end
      S_V13, S_P2: ctl.imp_ld = 1'b1;
      S_VU1, S_PU1: begin
        kind_sel   = (state == S_PU1) ? cir_pkg::KIND_POS : cir_pkg::KIND_VEL;
        ctl.mul_en = 1'b1;
        ctl.mul_a  = cir_pkg::MA_IMP;
        ctl.mul_b  = cir_pkg::MB_G;
      end
      S_VU2, S_PU2: begin
        kind_sel  = (state == S_PU2) ? cir_pkg::KIND_POS : cir_pkg::KIND_VEL;
        ctl.w_sel = cir_pkg::W_ADD;
      end
      S_VU3: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = cir_pkg::MA_W;
        ctl.mul_b  = cir_pkg::MB_G2;
      end
      S_VU5, S_VU7: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = cir_pkg::MA_T;
        ctl.mul_b  = cir_pkg::MB_G2;
      end
      S_VU4, S_VU6, S_VU8: ctl.t_sel = cir_pkg::T_Q;
      S_VU9: ctl.w_sel = cir_pkg::W_DAMP;
      S_VU10: ctl.we = 1'b1;
      S_PR: kind_sel = cir_pkg::KIND_POS;
      S_PU3: begin
        kind_sel = cir_pkg::KIND_POS;
        ctl.we   = 1'b1;
      end
      S_CLEAR: begin
        ctl.we     = 1'b1;
        ctl.wd_sel = cir_pkg::WD_ZERO;
      end
      default: ;
    endcase
    addr = (state == S_CLEAR) ? clr_addr : {IW'(body_sel), kind_sel};
  end

  // Component lanes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    cir_lane #(
      .NUM_BODIES(NUM_BODIES),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .ctl (ctl),
      .addr(addr),
      .n_in(n_r[i]),
      .g   (g),
      .g2  (g2),
      .hb  (hb_r),
      .rdat(rdat[i]),
      .q   (q[i])
    );
  end

  cir_merge u_merge (
    .clk(clk),
    .q0 (q[0]),
    .q1 (q[1]),
    .q2 (q[2]),
    .dot(dot)
  );

  cir_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (tim[32:0]),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      restitution   <= cir_pkg::RESTITUTION_RST;
      friction_coef <= cir_pkg::FRICTION_RST;
      step_time     <= cir_pkg::STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cir_pkg::REG_RESTITUTION: restitution   <= cfg_data;
        cir_pkg::REG_FRICTION:    friction_coef <= cfg_data;
        cir_pkg::REG_STEP:        step_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, scalars and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      side     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r   <= s_tuser[1:0];
            kind_r <= s_tuser[3:2];
            a_r    <= s_tdata[5:0];
            b_r    <= s_tdata[11:6];
            hb_r   <= s_tdata[12];
            n_r[0] <= s_tdata[44:13];
            n_r[1] <= s_tdata[76:45];
            n_r[2] <= s_tdata[108:77];
            pen_r  <= s_tdata[140:109];
            vflag  <= 1'b0;
            pflag  <= 1'b0;
            side   <= 1'b0;
            res_x  <= '0;
            res_y  <= '0;
            res_z  <= '0;
            case (s_tuser[1:0])
              cir_pkg::OP_WRITE:   state <= a_ok ? S_WRITE : S_FIN;
              cir_pkg::OP_READ:    state <= a_ok ? S_READ : S_FIN;
              cir_pkg::OP_CONTACT: state <= (a_ok && (!s_tdata[12] || b_ok)) ? S_C0 : S_FIN;
              default:             state <= S_FIN;
            endcase
          end
        end
        S_WRITE: state <= S_FIN;
        S_READ:  state <= S_READ2;
        S_READ2: begin
          res_x <= rdat[0];
          res_y <= rdat[1];
          res_z <= (kind_r == cir_pkg::KIND_MASS) ? 32'sd0 : rdat[2];
          state <= S_FIN;
        end
        S_C0: state <= S_C1;
        S_C1: begin
          mass_a <= rdat[0];
          im_a   <= rdat[1];
          state  <= S_C2;
        end
        S_C2: begin
          mass_b <= rdat[0];
          im_b   <= hb_r ? rdat[1] : 32'sd0;
          neg_b  <= cir_pkg::sat32(-cir_pkg::sx32(rdat[1]));
          state  <= S_C3;
        end
        S_C3: begin
          tim   <= {im_a[31], im_a} + {im_b[31], im_b};
          state <= S_C4;
        end
        S_C4: state <= S_C5;
        S_C5: state <= S_C6;
        S_C6: state <= S_C7;
        // Separating velocity decides the impulse step
        S_C7: begin
          sv <= dot;
          if (dot[31] && tim_pos) begin
            g     <= cir_pkg::sat32(-cir_pkg::sx32(dot));
            g2    <= {15'b0, restitution};
            state <= S_V1;
          end else begin
            state <= S_P0;
          end
        end
        S_V1: state <= S_V2;
        S_V2: begin
          nsv   <= q0_sat;
          state <= S_V3;
        end
        S_V3: state <= S_V4;
        S_V4: state <= S_V5;
        S_V5: state <= S_V6;
        S_V6: state <= S_V7;
        S_V7: begin
          g     <= dot;
          g2    <= {15'b0, step_time};
          state <= S_V8;
        end
        S_V8: state <= S_V9;
        // Acceleration correction only when the term is negative
        S_V9: begin
          g     <= {15'b0, restitution};
          g2    <= q0_sat;
          state <= q0_sat[31] ? S_V10 : S_VDIV;
        end
        S_V10: state <= S_V11;
        S_V11: begin
          nsv   <= nsv_sum[31] ? 32'sd0 : nsv_sum;
          state <= S_VDIV;
        end
        S_VDIV: state <= S_VDW;
        S_VDW: begin
          if (div_done) begin
            g     <= div_quo;
            state <= S_V12;
          end
        end
        S_V12: state <= S_V13;
        S_V13: begin
          side  <= 1'b0;
          state <= S_VUR;
        end
        // Velocity update for body A, then body B
        S_VUR: begin
          g     <= side ? neg_b : im_a;
          g2    <= side ? mass_b : mass_a;
          state <= S_VU1;
        end
        S_VU1: state <= S_VU2;
        S_VU2: state <= S_VU3;
        S_VU3: state <= S_VU4;
        S_VU4: begin
          g2    <= {15'b0, friction_coef};
          state <= S_VU5;
        end
        S_VU5: state <= S_VU6;
        S_VU6: begin
          g2    <= {15'b0, step_time};
          state <= S_VU7;
        end
        S_VU7: state <= S_VU8;
        S_VU8: state <= S_VU9;
        S_VU9: state <= S_VU10;
        S_VU10: begin
          if (!side && hb_r) begin
            side  <= 1'b1;
            state <= S_VUR;
          end else begin
            vflag <= 1'b1;
            side  <= 1'b0;
            state <= S_P0;
          end
        end
        S_P0: state <= div_start ? S_PDW : S_FIN;
        S_PDW: begin
          if (div_done) begin
            g     <= div_quo;
            state <= S_P1;
          end
        end
        S_P1: state <= S_P2;
        S_P2: begin
          side  <= 1'b0;
          state <= S_PR;
        end
        // Position move for body A, then body B
        S_PR: begin
          g     <= side ? neg_b : im_a;
          state <= S_PU1;
        end
        S_PU1: state <= S_PU2;
        S_PU2: state <= S_PU3;
        S_PU3: begin
          if (!side && hb_r) begin
            side  <= 1'b1;
            state <= S_PR;
          end else begin
            pflag <= 1'b1;
            state <= S_FIN;
          end
        end
        // Hand the result to the output register
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_z, res_y, res_x};
            m_tuser  <= {pflag, vflag};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CIR_ASSERT_IMP(a_clear_blocks_input, state == S_CLEAR, !s_tready, "input taken during clear")
  `CIR_ASSERT_IMP(a_flags_zero_data, m_tvalid && (m_tuser != 2'b00), m_tdata == '0,
                  "contact result carries data")
  `CIR_ASSERT_IMP(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
  `CIR_ASSERT_NXT(a_fin_delivers, state == S_FIN && (!m_tvalid || m_tready), m_tvalid,
                  "finished item not presented")

endmodule
